// ----- rtl/core/rfds_pkg.sv -----
package rfds_pkg;

   // ring and frame constants
   localparam int unsigned RFDS_RING_DEPTH = 2048;
   localparam int unsigned FLEN_W          = 15;
   localparam int unsigned LEN_W           = 14;
   localparam int unsigned LIMIT_W         = 16;

   localparam logic [7:0]         START_BYTE  = 8'h68;
   localparam logic [7:0]         END_BYTE    = 8'h16;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd10;

   // command codes
   typedef enum logic [1:0] {
      CMD_PUSH = 2'd0,
      CMD_POLL = 2'd1,
      CMD_READ = 2'd2
   } cmd_type;

   // request transaction
   typedef struct packed {
      logic [1:0] command;
      logic [7:0] rx_byte;
   } req_payload_type;

   // response transaction
   typedef struct packed {
      logic              frame_ready;
      logic [FLEN_W-1:0] frame_size;
      logic [7:0]        out_byte;
      logic              byte_valid;
      logic              byte_last;
      logic              push_dropped;
      logic              searching;
   } rsp_payload_type;

endpackage

// ----- rtl/core/rfds_chan_if.sv -----
interface rfds_req_if;
   import rfds_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface rfds_rsp_if;
   import rfds_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/ring_frame_delimiter_sync.sv -----
// start/length/end frame synchronizer over a byte ring held in one memory
//
// req_chan carries one command per transaction: push a received byte, poll one
// step of the frame sync machine, or read one byte of an accepted frame. Each
// request transaction produces exactly one rsp_chan transaction. csr_wr_en with
// csr_wr_data sets the wait limit (polls to wait for missing or end bytes).
// One request is worked at a time. Push, read and ignored commands pass
// S_PUSH, S_READ or S_FIN before the response loads. A poll in the search
// phase examines ring entries in S_SRCH, the ring memory giving one byte per
// cycle. A poll in the length phase reads header bytes in S_HDR1 and S_HDR2,
// checks in S_CHK and reads the end byte in S_END (all memory reads).
// The response register frees the request side: a new request is taken while
// the previous response still waits; the next response waits in its final
// step until rsp_chan.ready drains the register.
// Reset is synchronous: pointers, phase and counters clear, the wait limit
// returns to 10. Ring contents are not cleared; only written bytes are read.
module ring_frame_delimiter_sync #(
   parameter int unsigned RING_DEPTH = rfds_pkg::RFDS_RING_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   rfds_req_if.sink                         req_chan,
   rfds_rsp_if.source                       rsp_chan,
   input  logic                             csr_wr_en,
   input  logic [rfds_pkg::LIMIT_W-1:0]     csr_wr_data
);
   import rfds_pkg::*;

   localparam int unsigned PTR_W = $clog2(RING_DEPTH);
   localparam int unsigned CW    = (PTR_W > FLEN_W) ? PTR_W : FLEN_W;
   localparam logic [PTR_W:0] DEPTH_EXT = (PTR_W+1)'(RING_DEPTH);

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_PUSH = 9'b000000010,
      S_READ = 9'b000000100,
      S_SRCH = 9'b000001000,
      S_HDR1 = 9'b000010000,
      S_HDR2 = 9'b000100000,
      S_CHK  = 9'b001000000,
      S_END  = 9'b010000000,
      S_FIN  = 9'b100000000
   } state_type;

   // ring pointer arithmetic with wrap at the ring depth
   function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                 input logic [PTR_W-1:0] off);
      logic [PTR_W:0] s;
      s = {1'b0, p} + {1'b0, off};
      if (s >= DEPTH_EXT) begin
         s = s - DEPTH_EXT;
      end
      return s[PTR_W-1:0];
   endfunction

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return ptr_add(p, PTR_W'(1));
   endfunction

   state_type          state_ff, state_in;
   logic [PTR_W-1:0]   wp_ff, wp_in;
   logic [PTR_W-1:0]   rp_ff, rp_in;
   logic               phase_ff, phase_in;
   logic [LIMIT_W-1:0] wait_ff, wait_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [FLEN_W-1:0]  drain_ff, drain_in;
   logic [7:0]         byte_ff, byte_in;
   logic [7:0]         len_lo_ff, len_lo_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [PTR_W-1:0]   used_ff, used_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_data_ff, rsp_data_in;

   logic [7:0]         ring_mem [0:RING_DEPTH-1];
   logic [7:0]         rd_data_ff;
   logic               mem_we;
   logic               mem_re;
   logic [PTR_W-1:0]   mem_raddr;

   logic               out_free;
   logic               load_rsp;
   logic               wait_step;
   rsp_payload_type    rsp_new;
   logic [PTR_W:0]     used_wide;
   logic [PTR_W-1:0]   used_now;
   logic [FLEN_W-1:0]  len_p1;
   logic [FLEN_W-1:0]  len_p2;
   logic               frame_fits;

   // bytes currently buffered
   always_comb begin
      if (wp_ff >= rp_ff) begin
         used_wide = {1'b0, wp_ff} - {1'b0, rp_ff};
      end else begin
         used_wide = {1'b0, wp_ff} + DEPTH_EXT - {1'b0, rp_ff};
      end
      used_now = used_wide[PTR_W-1:0];
   end

   // frame size checks from the registered length
   assign len_p1     = FLEN_W'(len_ff) + FLEN_W'(1);
   assign len_p2     = FLEN_W'(len_ff) + FLEN_W'(2);
   assign frame_fits = CW'(used_ff) >= CW'(len_p2);

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // sequencer: dispatch, memory reads, read-modify-write of sync state
   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      phase_in     = phase_ff;
      wait_in      = wait_ff;
      limit_in     = limit_ff;
      drain_in     = drain_ff;
      byte_in      = byte_ff;
      len_lo_in    = len_lo_ff;
      len_in       = len_ff;
      used_in      = used_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_raddr    = rp_ff;
      load_rsp     = 1'b0;
      wait_step    = 1'b0;
      rsp_new      = '0;

      if (csr_wr_en) begin
         limit_in = csr_wr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               byte_in  = req_chan.data.rx_byte;
               state_in = S_FIN;
               case (req_chan.data.command)
                  CMD_PUSH: begin
                     state_in = S_PUSH;
                  end
                  CMD_READ: begin
                     if (drain_ff != '0) begin
                        mem_re    = 1'b1;
                        mem_raddr = rp_ff;
                        state_in  = S_READ;
                     end
                  end
                  CMD_POLL: begin
                     if (drain_ff == '0) begin
                        if (!phase_ff) begin
                           if (rp_ff != wp_ff) begin
                              mem_re    = 1'b1;
                              mem_raddr = rp_ff;
                              state_in  = S_SRCH;
                           end
                        end else if (used_now >= PTR_W'(3)) begin
                           mem_re    = 1'b1;
                           mem_raddr = ptr_inc(rp_ff);
                           used_in   = used_now;
                           state_in  = S_HDR1;
                        end
                     end
                  end
                  default: begin
                     state_in = S_FIN;
                  end
               endcase
            end
         end
         S_PUSH: begin
            if (out_free) begin
               if (ptr_inc(wp_ff) == rp_ff) begin
                  rsp_new.push_dropped = 1'b1;
               end else begin
                  mem_we = 1'b1;
                  wp_in  = ptr_inc(wp_ff);
               end
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_READ: begin
            if (out_free) begin
               rsp_new.out_byte   = rd_data_ff;
               rsp_new.byte_valid = 1'b1;
               rsp_new.byte_last  = (drain_ff == FLEN_W'(1));
               rp_in              = ptr_inc(rp_ff);
               drain_in           = drain_ff - FLEN_W'(1);
               load_rsp           = 1'b1;
               state_in           = S_IDLE;
            end
         end
         S_SRCH: begin
            // one ring entry per cycle until a start byte or an empty ring
            if (rd_data_ff == START_BYTE) begin
               if (out_free) begin
                  phase_in = 1'b1;
                  load_rsp = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (ptr_inc(rp_ff) == wp_ff) begin
               if (out_free) begin
                  rp_in    = ptr_inc(rp_ff);
                  load_rsp = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               rp_in     = ptr_inc(rp_ff);
               mem_re    = 1'b1;
               mem_raddr = ptr_inc(rp_ff);
            end
         end
         S_HDR1: begin
            len_lo_in = rd_data_ff;
            mem_re    = 1'b1;
            mem_raddr = ptr_add(rp_ff, PTR_W'(2));
            state_in  = S_HDR2;
         end
         S_HDR2: begin
            len_in   = {rd_data_ff[LEN_W-9:0], len_lo_ff};
            state_in = S_CHK;
         end
         S_CHK: begin
            if (len_ff == '0) begin
               // zero length: skip the start byte, keep the wait count
               if (out_free) begin
                  rp_in    = ptr_inc(rp_ff);
                  phase_in = 1'b0;
                  load_rsp = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (frame_fits) begin
               mem_re    = 1'b1;
               mem_raddr = ptr_add(rp_ff, len_p1[PTR_W-1:0]);
               state_in  = S_END;
            end else if (out_free) begin
               wait_step = 1'b1;
               load_rsp  = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_END: begin
            if (out_free) begin
               if (rd_data_ff == END_BYTE) begin
                  wait_in             = '0;
                  phase_in            = 1'b0;
                  drain_in            = len_p2;
                  rsp_new.frame_ready = 1'b1;
                  rsp_new.frame_size  = len_p2;
               end else begin
                  wait_step = 1'b1;
               end
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_FIN: begin
            if (out_free) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // incomplete frame: count a poll or give up on this start byte
      if (wait_step) begin
         if (wait_ff < limit_ff) begin
            wait_in = wait_ff + LIMIT_W'(1);
         end else begin
            wait_in  = '0;
            rp_in    = ptr_inc(rp_ff);
            phase_in = 1'b0;
         end
      end

      // response register load
      if (load_rsp) begin
         rsp_new.searching = !phase_in;
         rsp_valid_in      = 1'b1;
         rsp_data_in       = rsp_new;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         phase_ff     <= 1'b0;
         wait_ff      <= '0;
         limit_ff     <= LIMIT_RESET;
         drain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         phase_ff     <= phase_in;
         wait_ff      <= wait_in;
         limit_ff     <= limit_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      len_lo_ff   <= len_lo_in;
      len_ff      <= len_in;
      used_ff     <= used_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ring memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[wp_ff] <= byte_ff;
      end
      if (mem_re) begin
         rd_data_ff <= ring_mem[mem_raddr];
      end
   end

   // a pending frame only exists in the search phase
   a_drain_in_search: assert property (@(posedge clock) disable iff (reset)
      (drain_ff != '0) |-> !phase_ff)
      else $error("frame pending while in length phase");

   // the length phase always has its start byte buffered
   a_length_phase_nonempty: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (wp_ff != rp_ff))
      else $error("length phase with empty ring");

   // a pending frame never exceeds the buffered bytes
   a_drain_buffered: assert property (@(posedge clock) disable iff (reset)
      CW'(drain_ff) <= CW'(used_now))
      else $error("pending frame larger than ring contents");

   // no write into a full ring
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (ptr_inc(wp_ff) != rp_ff))
      else $error("ring written while full");

endmodule
